// ===== rtl/lagged_bit_pair_counter_defines.svh =====
// Assertion macros used by the RTL file that checks its own logic.
`ifndef LAGGED_BIT_PAIR_COUNTER_DEFINES_SVH
`define LAGGED_BIT_PAIR_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
`define LBPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbpc check failed");
`define LBPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbpc check failed");
`else
`define LBPC_ASSERT_NOW(label, ante, cons)
`define LBPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/lbpc_pkg.sv =====
`default_nettype none

package lbpc_pkg;

  localparam int HISTORY_WORDS = 64;
  localparam int NUM_LAGS      = 4;
  localparam int NUM_LAG_REGS  = 4;

  localparam int WORD_W     = 64;
  localparam int COUNT_W    = 48;
  localparam int LAG_W      = 12;
  localparam int SHIFT_W    = 6;
  localparam int USED_W     = 3;
  localparam int IDX_W      = 2;
  localparam int LANE_IDX_W = (NUM_LAGS > 1) ? $clog2(NUM_LAGS) : 1;
  localparam int PC_W       = 7;
  localparam int BYTE_CNT_W = 4;
  localparam int NUM_BYTES  = WORD_W / 8;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [2:0] REG_LAGS_IN_USE = 3'd0;
  localparam logic [2:0] REG_LAG_ZERO    = 3'd1;
  localparam logic [2:0] REG_LAG_ONE     = 3'd2;
  localparam logic [2:0] REG_LAG_TWO     = 3'd3;
  localparam logic [2:0] REG_LAG_THREE   = 3'd4;

  // Control that travels down the counting pipeline with each word.
  typedef struct packed {
    logic vld;
    logic eor;
  } lbpc_ctl_t;

  // Per history cell: which lags take this cell as their low or high tap.
  typedef struct packed {
    logic [NUM_LAGS-1:0] lo;
    logic [NUM_LAGS-1:0] hi;
  } lbpc_tap_sel_t;

  typedef logic [NUM_LAGS-1:0][WORD_W-1:0] lbpc_lag_words_t;

endpackage

`default_nettype wire

// ===== rtl/lbpc_hist_cell.sv =====
`default_nettype none

module lbpc_hist_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            shift_en,
  input  logic [lbpc_pkg::WORD_W-1:0]     word_in,
  input  lbpc_pkg::lbpc_tap_sel_t         sel,
  output logic [lbpc_pkg::WORD_W-1:0]     word_out,
  output lbpc_pkg::lbpc_lag_words_t       tap_lo,
  output lbpc_pkg::lbpc_lag_words_t       tap_hi
);
  import lbpc_pkg::*;

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else if (shift_en) begin
      word_r <= word_in;
    end
  end

  assign word_out = word_r;

  always_comb begin
    for (int k = 0; k < NUM_LAGS; k++) begin
      tap_lo[k] = sel.lo[k] ? word_r : '0;
      tap_hi[k] = sel.hi[k] ? word_r : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbpc_lag_lane.sv =====
`default_nettype none

module lbpc_lag_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [lbpc_pkg::WORD_W-1:0]      tap_lo,
  input  logic [lbpc_pkg::WORD_W-1:0]      tap_hi,
  input  logic [lbpc_pkg::WORD_W-1:0]      word,
  input  logic [lbpc_pkg::SHIFT_W-1:0]     bit_offset,
  input  lbpc_pkg::lbpc_ctl_t              ctl,
  output logic [lbpc_pkg::COUNT_W-1:0]     total
);
  import lbpc_pkg::*;

  localparam int AMT_W = SHIFT_W + 1;

  logic [AMT_W-1:0]      shift_amt;
  logic [2*WORD_W-1:0]   pair_shifted;
  logic [WORD_W-1:0]     hits_r;
  logic [BYTE_CNT_W-1:0] byte_cnt_nxt [NUM_BYTES];
  logic [BYTE_CNT_W-1:0] byte_cnt_r   [NUM_BYTES];
  logic [PC_W-1:0]       pc_nxt;
  logic [PC_W-1:0]       pc_r;
  logic [COUNT_W:0]      sum;
  logic [COUNT_W-1:0]    acc_r;

  // Shifting the pair {low tap, high tap} right by 64 - bit_offset leaves
  // low << bit_offset | high >> (64 - bit_offset) in the bottom word.
  assign shift_amt    = AMT_W'(WORD_W) - {1'b0, bit_offset};
  assign pair_shifted = {tap_lo, tap_hi} >> shift_amt;

  always_comb begin
    for (int b = 0; b < NUM_BYTES; b++) begin
      byte_cnt_nxt[b] = '0;
      for (int t = 0; t < 8; t++) begin
        byte_cnt_nxt[b] = byte_cnt_nxt[b] + BYTE_CNT_W'(hits_r[8*b+t]);
      end
    end
  end

  always_comb begin
    pc_nxt = '0;
    for (int b = 0; b < NUM_BYTES; b++) begin
      pc_nxt = pc_nxt + PC_W'(byte_cnt_r[b]);
    end
  end

  always_ff @(posedge clk) begin
    hits_r <= pair_shifted[WORD_W-1:0] & word;
    for (int b = 0; b < NUM_BYTES; b++) begin
      byte_cnt_r[b] <= byte_cnt_nxt[b];
    end
    pc_r <= pc_nxt;
  end

  assign sum   = {1'b0, acc_r} + (COUNT_W+1)'(pc_r);
  assign total = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.vld) begin
      acc_r <= ctl.eor ? '0 : total;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbpc_report.sv =====
`default_nettype none

module lbpc_report (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          capture,
  input  logic [lbpc_pkg::COUNT_W-1:0]  totals [lbpc_pkg::NUM_LAGS],
  input  logic [lbpc_pkg::USED_W-1:0]   lags_in_use,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [lbpc_pkg::IDX_W-1:0]    out_lag_index,
  output logic [lbpc_pkg::COUNT_W-1:0]  out_pair_count,
  output logic                          out_last_count,
  output logic                          busy
);
  import lbpc_pkg::*;

  logic [COUNT_W-1:0] rpt_cnt_r [NUM_LAGS];
  logic [USED_W-1:0]  used_nxt;
  logic [USED_W-1:0]  used_r;
  logic [IDX_W-1:0]   idx_r;
  logic               busy_r;
  logic               last;
  logic               pop;

  always_comb begin
    if (lags_in_use == '0) begin
      used_nxt = USED_W'(1);
    end else if (lags_in_use > USED_W'(NUM_LAGS)) begin
      used_nxt = USED_W'(NUM_LAGS);
    end else begin
      used_nxt = lags_in_use;
    end
  end

  assign last = ({1'b0, idx_r} == (used_r - USED_W'(1)));
  assign pop  = busy_r && !out_stall;

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int k = 0; k < NUM_LAGS; k++) begin
        rpt_cnt_r[k] <= totals[k];
      end
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (capture) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (pop) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  assign out_valid      = busy_r;
  assign out_lag_index  = idx_r;
  assign out_pair_count = rpt_cnt_r[idx_r[LANE_IDX_W-1:0]];
  assign out_last_count = last;
  assign busy           = busy_r;

endmodule

`default_nettype wire

// ===== rtl/lagged_bit_pair_counter.sv =====
// Lagged bit-pair counter.
// Input channel: one 64-bit bitmap word per item with its count mask and an
// end_of_run flag; in_valid/in_stall, accepted when valid is high and stall low.
// Output channel: one count word per lag in use (lag 0 first, last_count on the
// final one), out_valid/out_stall, held steady while the receiver stalls.
// Throughput is one bitmap word per cycle while in_stall is low. Each word goes
// through a row of 64 history cells (one masked word each, shifting on every
// accepted word), a tap register, a hits register, byte counts, a popcount and
// the per-lag saturating accumulators.
// The report for an end_of_run word is captured when that word's control leaves
// ctl_s4 and then delivers one count per cycle while out_stall is low.
// Only one report is in flight at a time: an end_of_run word is stalled until
// the previous report has been fully taken; other words keep flowing.
// Reset clears the history, the counts and the report, and loads the register
// defaults (one lag in use, lags 1, 2, 3, 4). There is no clearing pass.
// The user must write the registers over the APB port only while the block is
// idle; the block itself does not enforce this. pready is always high.
`default_nettype none
`include "lagged_bit_pair_counter_defines.svh"

module lagged_bit_pair_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lbpc_pkg::WORD_W-1:0]   in_bitmap_word,
  input  logic [lbpc_pkg::WORD_W-1:0]   in_count_mask,
  input  logic                          in_end_of_run,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lbpc_pkg::IDX_W-1:0]    out_lag_index,
  output logic [lbpc_pkg::COUNT_W-1:0]  out_pair_count,
  output logic                          out_last_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lbpc_pkg::DATA_W-1:0]   pwdata,
  output logic [lbpc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lbpc_pkg::*;

  logic                               in_accept;
  logic [WORD_W-1:0]                  cur_masked;
  logic                               cfg_write;
  logic [2:0]                         reg_sel;
  logic [USED_W-1:0]                  lags_in_use_r;
  logic [USED_W-1:0]                  lags_in_use_nxt;
  logic [NUM_LAG_REGS-1:0][LAG_W-1:0] lag_r;
  logic [NUM_LAG_REGS-1:0][LAG_W-1:0] lag_nxt;
  logic [WORD_W-1:0]                  chain_in  [HISTORY_WORDS];
  logic [WORD_W-1:0]                  hist_word [HISTORY_WORDS];
  lbpc_lag_words_t                    cell_lo   [HISTORY_WORDS];
  lbpc_lag_words_t                    cell_hi   [HISTORY_WORDS];
  lbpc_lag_words_t                    tap_lo_nxt;
  lbpc_lag_words_t                    tap_hi_nxt;
  lbpc_lag_words_t                    tap_lo_r;
  lbpc_lag_words_t                    tap_hi_r;
  logic [WORD_W-1:0]                  word_s1_r;
  lbpc_ctl_t                          ctl_s1_r;
  lbpc_ctl_t                          ctl_s2_r;
  lbpc_ctl_t                          ctl_s3_r;
  lbpc_ctl_t                          ctl_s4_r;
  logic [COUNT_W-1:0]                 lane_total [NUM_LAGS];
  logic                               rpt_busy;
  logic                               eor_in_flight;

  assign in_accept  = in_valid && !in_stall;
  assign cur_masked = in_bitmap_word & in_count_mask;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = paddr[ADDR_W-1:2];

  always_comb begin
    lags_in_use_nxt = lags_in_use_r;
    lag_nxt         = lag_r;
    if (cfg_write) begin
      case (reg_sel)
        REG_LAGS_IN_USE: lags_in_use_nxt = pwdata[USED_W-1:0];
        REG_LAG_ZERO:    lag_nxt[0] = pwdata[LAG_W-1:0];
        REG_LAG_ONE:     lag_nxt[1] = pwdata[LAG_W-1:0];
        REG_LAG_TWO:     lag_nxt[2] = pwdata[LAG_W-1:0];
        REG_LAG_THREE:   lag_nxt[3] = pwdata[LAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lags_in_use_r <= USED_W'(1);
      for (int i = 0; i < NUM_LAG_REGS; i++) begin
        lag_r[i] <= LAG_W'(i + 1);
      end
    end else begin
      lags_in_use_r <= lags_in_use_nxt;
      lag_r         <= lag_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LAGS_IN_USE: prdata = DATA_W'(lags_in_use_r);
      REG_LAG_ZERO:    prdata = DATA_W'(lag_r[0]);
      REG_LAG_ONE:     prdata = DATA_W'(lag_r[1]);
      REG_LAG_TWO:     prdata = DATA_W'(lag_r[2]);
      REG_LAG_THREE:   prdata = DATA_W'(lag_r[3]);
      default:         prdata = '0;
    endcase
  end

  // History row: cell i holds the masked word of age i + 1. A lag whose word
  // shift is w reads age w as its low tap and age w + 1 as its high tap.
  for (genvar i = 0; i < HISTORY_WORDS; i++) begin : g_cell
    lbpc_tap_sel_t sel;

    if (i == 0) begin : g_head
      assign chain_in[i] = cur_masked;
    end else begin : g_link
      assign chain_in[i] = hist_word[i-1];
    end

    always_comb begin
      for (int k = 0; k < NUM_LAGS; k++) begin
        sel.lo[k] = (int'(lag_r[k][LAG_W-1:SHIFT_W]) == i + 1);
        sel.hi[k] = (int'(lag_r[k][LAG_W-1:SHIFT_W]) == i);
      end
    end

    lbpc_hist_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_accept),
      .word_in  (chain_in[i]),
      .sel      (sel),
      .word_out (hist_word[i]),
      .tap_lo   (cell_lo[i]),
      .tap_hi   (cell_hi[i])
    );
  end

  always_comb begin
    for (int k = 0; k < NUM_LAGS; k++) begin
      tap_lo_nxt[k] = (lag_r[k][LAG_W-1:SHIFT_W] == '0) ? cur_masked : '0;
      tap_hi_nxt[k] = '0;
      for (int i = 0; i < HISTORY_WORDS; i++) begin
        tap_lo_nxt[k] = tap_lo_nxt[k] | cell_lo[i][k];
        tap_hi_nxt[k] = tap_hi_nxt[k] | cell_hi[i][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    tap_lo_r  <= tap_lo_nxt;
    tap_hi_r  <= tap_hi_nxt;
    word_s1_r <= in_bitmap_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s1_r <= '0;
      ctl_s2_r <= '0;
      ctl_s3_r <= '0;
      ctl_s4_r <= '0;
    end else begin
      ctl_s1_r.vld <= in_accept;
      ctl_s1_r.eor <= in_accept && in_end_of_run;
      ctl_s2_r     <= ctl_s1_r;
      ctl_s3_r     <= ctl_s2_r;
      ctl_s4_r     <= ctl_s3_r;
    end
  end

  for (genvar k = 0; k < NUM_LAGS; k++) begin : g_lane
    lbpc_lag_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .tap_lo     (tap_lo_r[k]),
      .tap_hi     (tap_hi_r[k]),
      .word       (word_s1_r),
      .bit_offset (lag_r[k][SHIFT_W-1:0]),
      .ctl        (ctl_s4_r),
      .total      (lane_total[k])
    );
  end

  lbpc_report u_report (
    .clk            (clk),
    .rst_n          (rst_n),
    .capture        (ctl_s4_r.vld && ctl_s4_r.eor),
    .totals         (lane_total),
    .lags_in_use    (lags_in_use_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_lag_index  (out_lag_index),
    .out_pair_count (out_pair_count),
    .out_last_count (out_last_count),
    .busy           (rpt_busy)
  );

  // An end word may only enter once the previous report has left entirely.
  assign eor_in_flight = ctl_s1_r.eor || ctl_s2_r.eor || ctl_s3_r.eor ||
                         ctl_s4_r.eor || rpt_busy;
  assign in_stall      = in_end_of_run && eor_in_flight;

  `LBPC_ASSERT_NOW(a_report_free, ctl_s4_r.vld && ctl_s4_r.eor, !rpt_busy)
  `LBPC_ASSERT_NOW(a_one_report, 1'b1, $countones({ctl_s1_r.eor, ctl_s2_r.eor, ctl_s3_r.eor, ctl_s4_r.eor, rpt_busy}) <= 1)
  `LBPC_ASSERT_NEXT(a_report_ends, out_valid && !out_stall && out_last_count, !out_valid)
  `LBPC_ASSERT_NEXT(a_hist_head, in_accept, hist_word[0] == $past(cur_masked))

endmodule

`default_nettype wire
